// ===== src/overwrite_fifo_with_average_top_macros.svh =====
// Assertion macros shared by the overwrite FIFO RTL.
// Define NO_ASSERTIONS to compile every assertion away.
`ifndef OVERWRITE_FIFO_WITH_AVERAGE_TOP_MACROS_SVH
`define OVERWRITE_FIFO_WITH_AVERAGE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

`define OFA_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`define OFA_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`else

`define OFA_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg)

`define OFA_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)

`endif

`endif

// ===== src/ofa_pkg.sv =====
// Package for the overwrite FIFO with running mean: sizes, codes, types.
// No dependencies; used by the top module and the divider.
package ofa_pkg;

    localparam int SLOTS    = 8;
    localparam int KEY_W    = 32;
    localparam int YEAR_W   = 16;
    localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W    = IDX_W;
    localparam int SUM_W    = YEAR_W + CNT_W;
    localparam int STEP_W   = $clog2(SUM_W + 1);
    localparam int ENTRY_W  = KEY_W + YEAR_W;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_INSERTED = 2'd0;
    localparam logic [1:0] STATUS_REMOVED  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_START,
        S_DIV,
        S_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== src/overwrite_fifo_with_average_top.sv =====
// Circular FIFO of SLOTS-1 entries (key, signed year) that drops its oldest entry when an
// insert arrives full, and reports the mean held year after every insert, truncated toward
// zero. A remove returns the oldest key, or status 2 with no state change when empty.
// One transaction is worked on at a time. An insert keeps the block busy through the
// bit-serial divider, which produces one quotient bit of the running sum divided by the
// held count per cycle; a remove reads the oldest entry before it returns, and a remove on
// empty skips the read. The result waits in an output register, so the next
// transaction is accepted while it is still pending. Depends on ofa_pkg, ofa_ram, ofa_div.
`include "overwrite_fifo_with_average_top_macros.svh"

module overwrite_fifo_with_average_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_op,
    input  logic [ofa_pkg::KEY_W-1:0]         s_item_key,
    input  logic signed [ofa_pkg::YEAR_W-1:0] s_birth_year,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_status,
    output logic signed [ofa_pkg::YEAR_W-1:0] m_mean_year,
    output logic [ofa_pkg::KEY_W-1:0]         m_removed_key
);

    ofa_pkg::state_t state_reg, state_next;

    logic                              op_reg,         op_next;
    logic signed [ofa_pkg::YEAR_W-1:0] year_reg,       year_next;
    logic [ofa_pkg::IDX_W-1:0]         head_reg,       head_next;
    logic [ofa_pkg::IDX_W-1:0]         tail_reg,       tail_next;
    logic [ofa_pkg::CNT_W-1:0]         count_reg,      count_next;
    logic signed [ofa_pkg::SUM_W-1:0]  sum_reg,        sum_next;
    logic                              neg_reg,        neg_next;
    logic [1:0]                        res_status_reg, res_status_next;
    logic [ofa_pkg::KEY_W-1:0]         res_key_reg,    res_key_next;
    logic                              m_valid_reg,    m_valid_next;
    logic [1:0]                        m_status_reg,   m_status_next;
    logic signed [ofa_pkg::YEAR_W-1:0] m_mean_reg,     m_mean_next;
    logic [ofa_pkg::KEY_W-1:0]         m_key_reg,      m_key_next;

    logic                              accept;
    logic                              full;
    logic                              ram_wr_en;
    logic [ofa_pkg::ENTRY_W-1:0]       ram_rd_data;
    logic signed [ofa_pkg::YEAR_W-1:0] old_year;
    logic                              div_start;
    logic [ofa_pkg::SUM_W-1:0]         div_dividend;
    ofa_pkg::div_stat_t                div_stat;
    logic [ofa_pkg::SUM_W-1:0]         div_quotient;
    logic [ofa_pkg::SUM_W-1:0]         mean_full;
    logic [ofa_pkg::IDX_W:0]           ptr_sum;

    assign s_ready   = (state_reg == ofa_pkg::S_IDLE);
    assign accept    = s_valid && s_ready;
    assign full      = (count_reg == ofa_pkg::CNT_W'(ofa_pkg::SLOTS - 1));
    assign ram_wr_en = accept && (s_op == ofa_pkg::OP_INSERT);
    assign old_year  = ram_rd_data[ofa_pkg::YEAR_W-1:0];
    assign mean_full = neg_reg ? (~div_quotient + 1'b1) : div_quotient;

    ofa_ram #(
        .WIDTH (ofa_pkg::ENTRY_W),
        .DEPTH (ofa_pkg::SLOTS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (tail_reg),
        .wr_data ({s_item_key, s_birth_year}),
        .rd_en   (accept),
        .rd_addr (head_reg),
        .rd_data (ram_rd_data)
    );

    ofa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (count_reg),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        year_next       = year_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        neg_next        = neg_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_mean_next     = m_mean_reg;
        m_key_next      = m_key_reg;
        div_start       = 1'b0;
        div_dividend    = sum_reg[ofa_pkg::SUM_W-1] ? ofa_pkg::SUM_W'(-sum_reg)
                                                   : ofa_pkg::SUM_W'(sum_reg);
        case (state_reg)
            ofa_pkg::S_IDLE: begin
                if (accept) begin
                    op_next   = s_op;
                    year_next = s_birth_year;
                    if (s_op == ofa_pkg::OP_REMOVE && count_reg == '0) begin
                        res_status_next = ofa_pkg::STATUS_EMPTY;
                        res_key_next    = '0;
                        state_next      = ofa_pkg::S_OUT;
                    end else begin
                        state_next = ofa_pkg::S_READ;
                    end
                end
            end
            ofa_pkg::S_READ: begin
                if (op_reg == ofa_pkg::OP_INSERT) begin
                    tail_next = (tail_reg == ofa_pkg::IDX_W'(ofa_pkg::SLOTS - 1))
                                ? '0 : tail_reg + 1'b1;
                    if (full) begin
                        head_next = (head_reg == ofa_pkg::IDX_W'(ofa_pkg::SLOTS - 1))
                                    ? '0 : head_reg + 1'b1;
                        sum_next  = sum_reg + ofa_pkg::SUM_W'(year_reg)
                                    - ofa_pkg::SUM_W'(old_year);
                    end else begin
                        count_next = count_reg + 1'b1;
                        sum_next   = sum_reg + ofa_pkg::SUM_W'(year_reg);
                    end
                    res_status_next = ofa_pkg::STATUS_INSERTED;
                    res_key_next    = '0;
                    state_next      = ofa_pkg::S_START;
                end else begin
                    head_next = (head_reg == ofa_pkg::IDX_W'(ofa_pkg::SLOTS - 1))
                                ? '0 : head_reg + 1'b1;
                    count_next      = count_reg - 1'b1;
                    sum_next        = sum_reg - ofa_pkg::SUM_W'(old_year);
                    res_status_next = ofa_pkg::STATUS_REMOVED;
                    res_key_next    = ram_rd_data[ofa_pkg::ENTRY_W-1:ofa_pkg::YEAR_W];
                    state_next      = ofa_pkg::S_OUT;
                end
            end
            ofa_pkg::S_START: begin
                div_start  = 1'b1;
                neg_next   = sum_reg[ofa_pkg::SUM_W-1];
                state_next = ofa_pkg::S_DIV;
            end
            ofa_pkg::S_DIV: begin
                if (div_stat.done) begin
                    state_next = ofa_pkg::S_OUT;
                end
            end
            ofa_pkg::S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_key_next    = res_key_reg;
                    m_mean_next   = (res_status_reg == ofa_pkg::STATUS_INSERTED)
                                    ? mean_full[ofa_pkg::YEAR_W-1:0] : '0;
                    state_next    = ofa_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ofa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ofa_pkg::S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg         <= op_next;
        year_reg       <= year_next;
        neg_reg        <= neg_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        m_status_reg   <= m_status_next;
        m_mean_reg     <= m_mean_next;
        m_key_reg      <= m_key_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_mean_year   = m_mean_reg;
    assign m_removed_key = m_key_reg;

    assign ptr_sum = (ofa_pkg::IDX_W + 1)'(head_reg) + (ofa_pkg::IDX_W + 1)'(count_reg);

    `OFA_ASSERT_IMPLY(a_ptr_track, aclk, aresetn, state_reg == ofa_pkg::S_IDLE, (ptr_sum == (ofa_pkg::IDX_W + 1)'(tail_reg)) || (ptr_sum == (ofa_pkg::IDX_W + 1)'(tail_reg) + (ofa_pkg::IDX_W + 1)'(ofa_pkg::SLOTS)), "head, count and tail disagree")
    `OFA_ASSERT_IMPLY(a_empty_sum, aclk, aresetn, count_reg == '0, sum_reg == '0, "empty FIFO with non-zero sum")
    `OFA_ASSERT_IMPLY(a_div_state, aclk, aresetn, div_stat.done, state_reg == ofa_pkg::S_DIV, "divider finished outside divide state")

endmodule

// ===== src/ofa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
module ofa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                        aclk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/ofa_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, unsigned operands.
// Depends on ofa_pkg and the assertion macro header.
`include "overwrite_fifo_with_average_top_macros.svh"

module ofa_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [ofa_pkg::SUM_W-1:0] dividend,
    input  logic [ofa_pkg::CNT_W-1:0] divisor,
    output ofa_pkg::div_stat_t        stat,
    output logic [ofa_pkg::SUM_W-1:0] quotient
);

    logic                       busy_reg,  busy_next;
    logic                       done_reg,  done_next;
    logic [ofa_pkg::STEP_W-1:0] step_reg,  step_next;
    logic [ofa_pkg::CNT_W-1:0]  rem_reg,   rem_next;
    logic [ofa_pkg::SUM_W-1:0]  quo_reg,   quo_next;
    logic [ofa_pkg::CNT_W-1:0]  dsr_reg,   dsr_next;
    logic [ofa_pkg::CNT_W:0]    trial;
    logic [ofa_pkg::CNT_W:0]    diff;
    logic                       ge;

    always_comb begin
        trial     = {rem_reg, quo_reg[ofa_pkg::SUM_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        ge        = (trial >= {1'b0, dsr_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = ofa_pkg::STEP_W'(ofa_pkg::SUM_W);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[ofa_pkg::CNT_W-1:0] : trial[ofa_pkg::CNT_W-1:0];
            quo_next  = {quo_reg[ofa_pkg::SUM_W-2:0], ge};
            step_next = step_reg - 1'b1;
            if (step_reg == ofa_pkg::STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

    `OFA_ASSERT_IMPLY(a_start_idle, aclk, aresetn, start, !busy_reg, "divider started while busy")
    `OFA_ASSERT_NEXT(a_start_busy, aclk, aresetn, start, busy_reg, "divider failed to start")
    `OFA_ASSERT_IMPLY(a_rem_bound, aclk, aresetn, done_reg, rem_reg < dsr_reg, "remainder too large")

endmodule
